// ===== design/pfa_pkg.sv =====
package pfa_pkg;

	localparam logic [1:0] REQ_SET     = 2'd0;
	localparam logic [1:0] REQ_ALLOC   = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_NONE    = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_FND  = 2'd3;

	localparam logic [1:0] MODE_FIRST  = 2'd0;
	localparam logic [1:0] MODE_BEST   = 2'd1;
	localparam logic [1:0] MODE_WORST  = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	localparam int ID_W  = 16;
	localparam int ORD_W = 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BSCAN,
		S_BLAST,
		S_ESCAN,
		S_ELAST,
		S_RSCAN,
		S_RLAST,
		S_FREAD,
		S_UPDATE,
		S_OUT
	} state_t;

endpackage

// ===== design/partition_fit_allocator.sv =====
// Set capacity and unknown requests pass from idle to update and output;
// allocate runs the partition scan, the entry-table scan, update and output;
// release runs the entry-table scan, a free-space read, update and output.
// One request at a time; each scan reads one memory word per cycle.
// A new request is accepted only once the result register has been taken.
// Reset: asynchronous, active low; clears control, valid bits, mode and order
// counter. A clearing pass then zeroes the free-space memory and holds off requests.
module partition_fit_allocator #(
	parameter int NUM_BLOCKS  = 8,
	parameter int MAX_ENTRIES = 32,
	parameter int SIZE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[1:0], proc_id[17:2], amount[33:18], block_index[36:34]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], chosen_block[4:2], free_after[20:5]
	output logic [23:0] m_tdata
);
	localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [SIZE_BITS-1:0] SMAX = {SIZE_BITS{1'b1}};
	localparam int ID_W_C = pfa_pkg::ID_W;

	// memories
	logic [SIZE_BITS-1:0] fs_mem [NUM_BLOCKS];
	logic [ID_W_C-1:0]    eid_mem [MAX_ENTRIES];
	logic [2:0]           eblk_mem [MAX_ENTRIES];
	logic [pfa_pkg::ORD_W-1:0] eord_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] evalid_q;

	pfa_pkg::state_t state_q, state_d;
	logic [1:0]  mode_q;
	logic [pfa_pkg::ORD_W-1:0] order_q;
	logic        clr_q;
	logic [BW:0] clr_cnt_q;

	logic [1:0]           req_q;
	logic [15:0]          id_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [2:0]           bidx_q;

	logic [BW:0] bcnt_q;
	logic [EW:0] ecnt_q;
	logic        found_q;
	logic [BW-1:0] best_q;
	logic [SIZE_BITS-1:0] best_fs_q;
	logic        slot_ok_q;
	logic [EW-1:0] slot_q;
	logic        hit_q;
	logic [EW-1:0] hit_q_e;
	logic [2:0]  hit_blk_q;
	logic [15:0] hit_age_q;

	// read ports, registered
	logic [BW-1:0] fs_raddr;
	logic [SIZE_BITS-1:0] fs_rd_q;
	logic [EW-1:0] e_raddr;
	logic [15:0] eid_rd_q;
	logic [2:0]  eblk_rd_q;
	logic [15:0] eord_rd_q;
	logic [EW-1:0] e_rd_idx_q;
	logic [BW-1:0] fs_rd_idx_q;

	logic [1:0]  out_st_q;
	logic [2:0]  out_blk_q;
	logic [15:0] out_fr_q;
	logic        mval_q;

	logic fs_we;
	logic [BW-1:0] fs_waddr;
	logic [SIZE_BITS-1:0] fs_wdata;

	logic in_acc;
	assign s_tready = (state_q == pfa_pkg::S_IDLE) && !clr_q && !mval_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = mval_q;
	assign m_tdata  = {3'd0, out_fr_q, out_blk_q, out_st_q};

	always_comb begin
		fs_raddr = bcnt_q[BW-1:0];
		if (state_q == pfa_pkg::S_FREAD) begin
			fs_raddr = hit_blk_q[BW-1:0];
		end
		e_raddr = ecnt_q[EW-1:0];
	end

	always_ff @(posedge clk) begin
		fs_rd_q     <= fs_mem[fs_raddr];
		fs_rd_idx_q <= fs_raddr;
		eid_rd_q    <= eid_mem[e_raddr];
		eblk_rd_q   <= eblk_mem[e_raddr];
		eord_rd_q   <= eord_mem[e_raddr];
		e_rd_idx_q  <= e_raddr;
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		if (state_q == pfa_pkg::S_UPDATE && req_q == pfa_pkg::REQ_ALLOC
				&& found_q && slot_ok_q) begin
			eid_mem[slot_q]  <= id_q;
			eblk_mem[slot_q] <= 3'(best_q);
			eord_mem[slot_q] <= order_q;
		end
	end

	logic bset_ok;
	assign bset_ok = 32'(bidx_q) < NUM_BLOCKS;

	// free-space write: clear pass, set, or update
	logic [SIZE_BITS:0] rsum;
	assign rsum = {1'b0, fs_rd_q} + {1'b0, size_q};
	always_comb begin
		fs_we = 1'b0;
		fs_waddr = clr_cnt_q[BW-1:0];
		fs_wdata = '0;
		if (clr_q) begin
			fs_we = 1'b1;
		end else if (state_q == pfa_pkg::S_UPDATE) begin
			unique case (req_q)
				pfa_pkg::REQ_SET: begin
					fs_we = bset_ok;
					fs_waddr = bidx_q[BW-1:0];
					fs_wdata = size_q;
				end
				pfa_pkg::REQ_ALLOC: begin
					fs_we = found_q && slot_ok_q;
					fs_waddr = best_q;
					fs_wdata = best_fs_q - size_q;
				end
				pfa_pkg::REQ_RELEASE: begin
					fs_we = hit_q;
					fs_waddr = hit_blk_q[BW-1:0];
					fs_wdata = rsum[SIZE_BITS] ? SMAX : rsum[SIZE_BITS-1:0];
				end
				default: fs_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic bscan_done, escan_done;
	assign bscan_done = 32'(bcnt_q) >= NUM_BLOCKS - 1;
	assign escan_done = 32'(ecnt_q) >= MAX_ENTRIES - 1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfa_pkg::S_IDLE: begin
				if (in_acc) begin
					unique case (s_tdata[1:0])
						pfa_pkg::REQ_ALLOC:   state_d = pfa_pkg::S_BSCAN;
						pfa_pkg::REQ_RELEASE: state_d = pfa_pkg::S_RSCAN;
						default:              state_d = pfa_pkg::S_UPDATE;
					endcase
				end
			end
			pfa_pkg::S_BSCAN:  if (bscan_done) state_d = pfa_pkg::S_BLAST;
			pfa_pkg::S_BLAST:  state_d = pfa_pkg::S_ESCAN;
			pfa_pkg::S_ESCAN:  if (escan_done) state_d = pfa_pkg::S_ELAST;
			pfa_pkg::S_ELAST:  state_d = pfa_pkg::S_UPDATE;
			pfa_pkg::S_RSCAN:  if (escan_done) state_d = pfa_pkg::S_RLAST;
			pfa_pkg::S_RLAST:  state_d = pfa_pkg::S_FREAD;
			pfa_pkg::S_FREAD:  state_d = pfa_pkg::S_UPDATE;
			pfa_pkg::S_UPDATE: state_d = pfa_pkg::S_OUT;
			pfa_pkg::S_OUT:    state_d = pfa_pkg::S_IDLE;
			default:           state_d = pfa_pkg::S_IDLE;
		endcase
	end

	// candidate evaluation on registered read data
	logic fits, take;
	logic [15:0] age;
	logic rmatch, rtake;
	assign fits = fs_rd_q >= size_q;
	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (mode_q == pfa_pkg::MODE_BEST) begin
				take = fs_rd_q < best_fs_q;
			end else if (mode_q == pfa_pkg::MODE_WORST) begin
				take = fs_rd_q > best_fs_q;
			end
		end
		age = order_q - eord_rd_q;
		rmatch = evalid_q[e_rd_idx_q] && (eid_rd_q == id_q);
		rtake = rmatch && (!hit_q || (eblk_rd_q < hit_blk_q)
			|| ((eblk_rd_q == hit_blk_q) && (age > hit_age_q)));
	end

	logic scan_b, scan_e, scan_r;
	assign scan_b = (state_q == pfa_pkg::S_BSCAN && bcnt_q != '0)
		|| state_q == pfa_pkg::S_BLAST;
	assign scan_e = state_q == pfa_pkg::S_ESCAN || state_q == pfa_pkg::S_ELAST;
	assign scan_r = (state_q == pfa_pkg::S_RSCAN && ecnt_q != '0)
		|| state_q == pfa_pkg::S_RLAST;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= s_tdata[1:0];
			id_q   <= s_tdata[17:2];
			size_q <= SIZE_BITS'(s_tdata[33:18]);
			bidx_q <= s_tdata[36:34];
		end
		if (scan_b && take) begin
			best_q    <= fs_rd_idx_q;
			best_fs_q <= fs_rd_q;
		end
		if (scan_e && !slot_ok_q && !evalid_q[e_rd_idx_q]) begin
			slot_q <= e_rd_idx_q;
		end
		if (scan_r && rtake) begin
			hit_q_e   <= e_rd_idx_q;
			hit_blk_q <= eblk_rd_q;
			hit_age_q <= age;
		end
		if (state_q == pfa_pkg::S_UPDATE) begin
			out_st_q  <= pfa_pkg::ST_DONE;
			out_blk_q <= 3'd0;
			out_fr_q  <= '0;
			unique case (req_q)
				pfa_pkg::REQ_SET: begin
					out_blk_q <= bidx_q;
					if (bset_ok) begin
						out_fr_q <= 16'(size_q);
					end else begin
						out_st_q <= pfa_pkg::ST_NO_FIT;
					end
				end
				pfa_pkg::REQ_ALLOC: begin
					if (!found_q) begin
						out_st_q <= pfa_pkg::ST_NO_FIT;
					end else if (!slot_ok_q) begin
						out_st_q <= pfa_pkg::ST_FULL;
					end else begin
						out_blk_q <= 3'(best_q);
						out_fr_q  <= 16'(fs_wdata);
					end
				end
				pfa_pkg::REQ_RELEASE: begin
					if (!hit_q) begin
						out_st_q <= pfa_pkg::ST_NOT_FND;
					end else begin
						out_blk_q <= hit_blk_q;
						out_fr_q  <= 16'(fs_wdata);
					end
				end
				default: out_st_q <= pfa_pkg::ST_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= pfa_pkg::MODE_FIRST;
			order_q   <= '0;
			evalid_q  <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			bcnt_q    <= '0;
			ecnt_q    <= '0;
			found_q   <= 1'b0;
			slot_ok_q <= 1'b0;
			hit_q     <= 1'b0;
			mval_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (32'(clr_cnt_q) >= NUM_BLOCKS - 1) begin
					clr_q <= 1'b0;
				end
			end
			if (in_acc) begin
				bcnt_q    <= '0;
				ecnt_q    <= '0;
				found_q   <= 1'b0;
				slot_ok_q <= 1'b0;
				hit_q     <= 1'b0;
			end
			if (state_q == pfa_pkg::S_BSCAN && !bscan_done) begin
				bcnt_q <= bcnt_q + 1'b1;
			end
			if ((state_q == pfa_pkg::S_ESCAN || state_q == pfa_pkg::S_RSCAN)
					&& !escan_done) begin
				ecnt_q <= ecnt_q + 1'b1;
			end
			if (scan_b && take) begin
				found_q <= 1'b1;
			end
			if (scan_e && !evalid_q[e_rd_idx_q]) begin
				slot_ok_q <= 1'b1;
			end
			if (scan_r && rtake) begin
				hit_q <= 1'b1;
			end
			if (state_q == pfa_pkg::S_UPDATE) begin
				if (req_q == pfa_pkg::REQ_ALLOC && found_q && slot_ok_q) begin
					evalid_q[slot_q] <= 1'b1;
					order_q <= order_q + 1'b1;
				end
				if (req_q == pfa_pkg::REQ_RELEASE && hit_q) begin
					evalid_q[hit_q_e] <= 1'b0;
				end
			end
			if (state_q == pfa_pkg::S_OUT) begin
				mval_q <= 1'b1;
			end else if (m_tready) begin
				mval_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/sv/pfa_checker.sv =====
module pfa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	// packed from the top bit down, so status lands in the lowest bits
	typedef struct packed {
		logic [15:0] free_after;
		logic [2:0]  chosen_block;
		logic [1:0]  status;
	} alloc_result_t;

	logic [1:0]  mode;
	logic [15:0] part_free [8];
	logic        slot_used [32];
	logic [15:0] slot_id [32];
	logic [2:0]  slot_part [32];
	logic [15:0] slot_seq [32];
	logic [15:0] seq_count;
	alloc_result_t answer_q[$];

	function automatic alloc_result_t predict_request(logic [39:0] d);
		logic [1:0]    kind;
		logic [15:0]   pid;
		logic [15:0]   sz;
		logic [2:0]    pidx;
		int            pick;
		int            slot;
		logic [15:0]   age;
		logic [15:0]   best_age;
		logic [16:0]   sum;
		alloc_result_t r;
		kind = d[1:0];
		pid  = d[17:2];
		sz   = d[33:18];
		pidx = d[36:34];
		r = '0;
		pick = -1;
		slot = -1;
		best_age = '0;
		case (kind)
			pfa_pkg::REQ_SET: begin
				part_free[pidx] = sz;
				r.status = pfa_pkg::ST_DONE;
				r.chosen_block = pidx;
				r.free_after = sz;
			end
			pfa_pkg::REQ_ALLOC: begin
				for (int b = 0; b < 8; b++) begin
					if (part_free[b] >= sz) begin
						if (pick < 0)
							pick = b;
						else if (mode == pfa_pkg::MODE_BEST
						         && part_free[b] < part_free[pick])
							pick = b;
						else if (mode == pfa_pkg::MODE_WORST
						         && part_free[b] > part_free[pick])
							pick = b;
						if (mode != pfa_pkg::MODE_BEST && mode != pfa_pkg::MODE_WORST)
							break;
					end
				end
				for (int e = 0; e < 32; e++) begin
					if (!slot_used[e] && slot < 0)
						slot = e;
				end
				if (pick < 0) begin
					r.status = pfa_pkg::ST_NO_FIT;
				end else if (slot < 0) begin
					r.status = pfa_pkg::ST_FULL;
				end else begin
					slot_used[slot] = 1'b1;
					slot_id[slot] = pid;
					slot_part[slot] = pick[2:0];
					slot_seq[slot] = seq_count;
					seq_count = seq_count + 16'd1;
					part_free[pick] = part_free[pick] - sz;
					r.status = pfa_pkg::ST_DONE;
					r.chosen_block = pick[2:0];
					r.free_after = part_free[pick];
				end
			end
			pfa_pkg::REQ_RELEASE: begin
				for (int e = 0; e < 32; e++) begin
					if (slot_used[e] && slot_id[e] == pid) begin
						age = seq_count - slot_seq[e];
						if (slot < 0 || slot_part[e] < slot_part[slot] ||
						    (slot_part[e] == slot_part[slot] && age > best_age)) begin
							slot = e;
							best_age = age;
						end
					end
				end
				if (slot < 0) begin
					r.status = pfa_pkg::ST_NOT_FND;
				end else begin
					slot_used[slot] = 1'b0;
					sum = {1'b0, part_free[slot_part[slot]]} + sz;
					part_free[slot_part[slot]] = sum[16] ? 16'hFFFF : sum[15:0];
					r.status = pfa_pkg::ST_DONE;
					r.chosen_block = slot_part[slot];
					r.free_after = part_free[slot_part[slot]];
				end
			end
			default: r.status = pfa_pkg::ST_DONE;
		endcase
		return r;
	endfunction

	assign pending = answer_q.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		alloc_result_t got;
		int errs;
		errs = 0;
		if (!arst_n) begin
			mode <= pfa_pkg::MODE_FIRST;
			seq_count <= '0;
			fail_count <= 0;
			result_count <= 0;
			for (int i = 0; i < 8; i++)
				part_free[i] <= '0;
			for (int i = 0; i < 32; i++)
				slot_used[i] <= 1'b0;
			answer_q.delete();
		end else begin
			if (cfg_we)
				mode = cfg_wdata;
			if (s_tvalid && s_tready)
				answer_q.insert(answer_q.size(), predict_request(s_tdata));
			if (m_tvalid && m_tready) begin
				result_count <= result_count + 1;
				got = m_tdata[20:0];
				if (answer_q.size() == 0) begin
					$error("result with no request pending: %h", m_tdata);
					errs++;
				end else begin
					want = answer_q.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errs++;
					end
					if (got.chosen_block !== want.chosen_block) begin
						$error("chosen_block: expected %0d, got %0d",
						       want.chosen_block, got.chosen_block);
						errs++;
					end
					if (got.free_after !== want.free_after) begin
						$error("free_after: expected %0d, got %0d",
						       want.free_after, got.free_after);
						errs++;
					end
				end
				fail_count <= fail_count + errs;
			end
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	int          fail_count;
	int          pending;
	int          result_count;
	int          cycle_count;
	int          request_count;

	localparam int CYCLE_LIMIT = 900000;

	partition_fit_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	pfa_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall count per result
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0)
				hold = 0;
			repeat (hold) @(posedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			m_tready <= 1'b0;
		end
	end

	task automatic send_request(logic [1:0] kind, logic [15:0] pid, logic [15:0] sz,
	                            logic [2:0] pidx, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, pidx, sz, pid, kind};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		request_count++;
	endtask

	task automatic write_mode(logic [1:0] m);
		// let the checker log the last request before looking at pending
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small ids so releases find their entries
	task automatic random_request(bit no_gap);
		int sel;
		logic [15:0] pid;
		logic [15:0] sz;
		sel = $urandom_range(0, 99);
		pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
		sz = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		if (sel < 12)
			send_request(pfa_pkg::REQ_SET, pid, ($urandom_range(0, 5) == 0) ? 16'($urandom)
			             : 16'($urandom_range(0, 20000)), 3'($urandom), no_gap);
		else if (sel < 58)
			send_request(pfa_pkg::REQ_ALLOC, pid, sz, 3'($urandom), no_gap);
		else if (sel < 96)
			send_request(pfa_pkg::REQ_RELEASE, pid, sz, 3'($urandom), no_gap);
		else
			send_request(pfa_pkg::REQ_NONE, 16'($urandom), 16'($urandom), 3'($urandom),
			             no_gap);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cycle_count = 0;
		request_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (20) @(posedge clk);

		// directed: empty partitions, extremes, each mode, saturation, bad request
		send_request(pfa_pkg::REQ_ALLOC, 16'd1, 16'd0, 3'd0, 0);
		send_request(pfa_pkg::REQ_RELEASE, 16'd1, 16'd5, 3'd0, 0);
		send_request(pfa_pkg::REQ_SET, 16'hFFFF, 16'hFFFF, 3'd7, 0);
		send_request(pfa_pkg::REQ_SET, 16'd0, 16'd100, 3'd1, 0);
		send_request(pfa_pkg::REQ_SET, 16'd0, 16'd300, 3'd2, 0);
		send_request(pfa_pkg::REQ_SET, 16'd0, 16'd100, 3'd3, 0);
		send_request(pfa_pkg::REQ_ALLOC, 16'd7, 16'd50, 3'd0, 0);
		send_request(pfa_pkg::REQ_ALLOC, 16'hFFFF, 16'hFFFF, 3'd0, 0);
		send_request(pfa_pkg::REQ_ALLOC, 16'd9, 16'hFFFF, 3'd0, 0);
		send_request(pfa_pkg::REQ_RELEASE, 16'hFFFF, 16'hFFFF, 3'd0, 0);
		send_request(pfa_pkg::REQ_NONE, 16'hFFFF, 16'hFFFF, 3'd7, 0);
		write_mode(pfa_pkg::MODE_BEST);
		send_request(pfa_pkg::REQ_ALLOC, 16'd7, 16'd40, 3'd0, 0);
		send_request(pfa_pkg::REQ_ALLOC, 16'd7, 16'd0, 3'd0, 0);
		send_request(pfa_pkg::REQ_RELEASE, 16'd7, 16'd10, 3'd0, 0);
		write_mode(pfa_pkg::MODE_WORST);
		send_request(pfa_pkg::REQ_ALLOC, 16'd8, 16'd100, 3'd0, 0);
		send_request(pfa_pkg::REQ_ALLOC, 16'd8, 16'd500, 3'd0, 0);
		write_mode(pfa_pkg::MODE_RSVD);
		send_request(pfa_pkg::REQ_ALLOC, 16'd8, 16'd10, 3'd0, 0);
		for (int i = 0; i < 32; i++)
			send_request(pfa_pkg::REQ_ALLOC, 16'd5, 16'd0, 3'd0, 1);
		send_request(pfa_pkg::REQ_RELEASE, 16'd5, 16'd1, 3'd0, 0);

		for (int phase = 0; phase < 8; phase++) begin
			write_mode(2'(phase));
			for (int i = 0; i < 250; i++)
				random_request(phase[0] && i < 60);
		end

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d requests (set, allocate, release, unknown) over all four",
		         request_count);
		$display("placement modes; %0d results checked.", result_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
design/pfa_pkg.sv
design/partition_fit_allocator.sv
tb/sv/pfa_checker.sv
tb/sv/tb.sv
